### design/amd_pkg.sv
// Shared constants and types for the anchor motion distributor.
`timescale 1ns / 1ps
`default_nettype none
package amd_pkg;
	localparam int MaxHeld = 16;
	localparam int HeldW = $clog2(MaxHeld + 1);
	localparam int IdxW = (MaxHeld > 1) ? $clog2(MaxHeld) : 1;
	localparam int PtsW = 48;
	localparam int MotW = 24;
	localparam int ConfW = 16;
	localparam int FracW = 26;

	typedef enum logic [0:0] {ACT_FRAME = 1'b0, ACT_FLUSH = 1'b1} action_t;

	typedef struct packed {
		logic [0:0] action;
		logic is_key;
		logic is_predicted;
		logic meas_valid;
		logic signed [MotW-1:0] in_dx;
		logic signed [MotW-1:0] in_dy;
		logic signed [MotW-1:0] in_theta;
		logic signed [MotW-1:0] in_scale;
		logic [ConfW-1:0] in_confidence;
		logic in_scene_cut;
		logic signed [PtsW-1:0] pts;
		logic pts_valid;
	} in_word_t;

	typedef struct packed {
		logic signed [MotW-1:0] out_dx;
		logic signed [MotW-1:0] out_dy;
		logic signed [MotW-1:0] out_theta;
		logic signed [MotW-1:0] out_scale;
		logic [ConfW-1:0] out_confidence;
		logic out_valid;
		logic out_scene_cut;
		logic interpolated;
		logic overflowed;
		logic end_of_run;
	} out_word_t;
endpackage
`default_nettype wire

### design/amd_if.sv
// Valid/ready channel carrying one word.
`timescale 1ns / 1ps
`default_nettype none
interface amd_in_if;
	import amd_pkg::*;
	logic valid;
	logic ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface amd_out_if;
	import amd_pkg::*;
	logic valid;
	logic ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/amd_share.sv
// Bit-serial fraction divider and share multiplier for one released frame.
`timescale 1ns / 1ps
`default_nettype none
module amd_share (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [amd_pkg::PtsW-1:0] num,
	input  wire logic [amd_pkg::PtsW-1:0] den,
	input  wire logic signed [amd_pkg::MotW-1:0] m0,
	input  wire logic signed [amd_pkg::MotW-1:0] m1,
	input  wire logic signed [amd_pkg::MotW-1:0] m2,
	input  wire logic signed [amd_pkg::MotW-1:0] m3,
	output logic done,
	output logic [4*amd_pkg::MotW-1:0] shares
);
	import amd_pkg::*;
	typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL} st_t;
	localparam int MagW = MotW;
	localparam int ProdW = MagW + FracW;

	st_t st_q;
	logic [5:0] cnt_q;
	logic [PtsW:0] r_q;
	logic [FracW-1:0] q_q;
	logic [PtsW-1:0] den_q;
	logic [FracW-1:0] f_q;
	logic [MagW-1:0] mag_q [4];
	logic [3:0] neg_q;
	logic [ProdW-1:0] acc_q [4];

	logic [PtsW:0] r_sh;
	logic r_ge;
	assign r_sh = {r_q[PtsW-1:0], 1'b0};
	assign r_ge = r_sh >= {1'b0, den_q};

	function automatic logic [MotW-1:0] fin(input logic [ProdW-1:0] a, input logic n);
		logic [ProdW-1:0] r;
		logic [MotW-1:0] v;
		r = (a + (ProdW'(1) << 23)) >> 24;
		v = r[MotW-1:0];
		return n ? -v : v;
	endfunction

	always_comb begin
		for (int k = 0; k < 4; k++)
			shares[k*MotW +: MotW] = fin(acc_q[k], neg_q[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						den_q <= den;
						// integer quotient bit first, then 25 fraction bits
						if (num >= den) begin
							q_q <= FracW'(1);
							r_q <= {1'b0, num - den};
						end else begin
							q_q <= '0;
							r_q <= {1'b0, num};
						end
						mag_q[0] <= m0[MotW-1] ? -m0 : m0;
						mag_q[1] <= m1[MotW-1] ? -m1 : m1;
						mag_q[2] <= m2[MotW-1] ? -m2 : m2;
						mag_q[3] <= m3[MotW-1] ? -m3 : m3;
						neg_q <= {m3[MotW-1], m2[MotW-1], m1[MotW-1], m0[MotW-1]};
						cnt_q <= '0;
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					q_q <= {q_q[FracW-2:0], r_ge};
					r_q <= r_ge ? r_sh - {1'b0, den_q} : r_sh;
					if (cnt_q == 6'd24) begin
						f_q <= ({q_q[FracW-2:0], r_ge} + FracW'(1)) >> 1;
						for (int k = 0; k < 4; k++) acc_q[k] <= '0;
						cnt_q <= '0;
						st_q <= S_MUL;
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				S_MUL: begin
					// one magnitude bit per cycle, msb first
					for (int k = 0; k < 4; k++)
						acc_q[k] <= (acc_q[k] << 1) +
							(mag_q[k][MagW-1] ? ProdW'(f_q) : '0);
					for (int k = 0; k < 4; k++)
						mag_q[k] <= mag_q[k] << 1;
					if (cnt_q == 6'(MagW - 1)) begin
						done <= 1'b1;
						st_q <= S_IDLE;
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_done_from_mul: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) == S_MUL) else $error("done outside multiply");
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> den_q != '0) else $error("zero divisor");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == S_IDLE) else $error("start while busy");
endmodule
`default_nettype wire

### design/anchor_motion_distributor.sv
// Top level of the anchor motion distributor.
`timescale 1ns / 1ps
`default_nettype none
// Frames come in one word at a time; each word yields zero to seventeen
// result words in frame order, the last marked end_of_run. Identity
// results leave one per cycle while the receiver is ready. A split result
// is formed by a 25-step restoring divider for the fraction, then a
// bit-serial 24-step multiply of the four motion fields, both in amd_share;
// the top fetches the duration, starts the unit, sees it finish and hands
// the word over. Each word is accepted, then decoded, before any result. The
// input is taken again only when every result of the previous word has left.
module anchor_motion_distributor (
	input wire logic clk,
	input wire logic arst_n,
	amd_in_if.sink in_ch,
	amd_out_if.source out_ch
);
	import amd_pkg::*;
	typedef enum logic [2:0] {S_IN, S_DECIDE, S_EMIT, S_CALC, S_WAIT, S_PUSH} st_t;

	st_t st_q;
	in_word_t w_q;
	logic started_q, last_ok_q, gaps_ok_q, use_ts_q;
	logic [PtsW-1:0] anchor_q, last_q, gap_q, total_q;
	logic [HeldW-1:0] held_q, idx_q, cnt_q;
	logic [PtsW-1:0] dur_mem [MaxHeld];
	logic [PtsW-1:0] dur_rd_q;
	logic ovf_q, split_q, self_q, hold_q, flush_q;
	logic sh_start, sh_done;
	logic [4*MotW-1:0] sh_res;
	logic id_emit_w;

	// one extra bit so the tick differences never wrap
	logic signed [PtsW:0] d_w, tot_w;
	logic gap_ok_w;
	assign d_w = {w_q.pts[PtsW-1], w_q.pts} - {last_q[PtsW-1], last_q};
	assign tot_w = {w_q.pts[PtsW-1], w_q.pts} - {anchor_q[PtsW-1], anchor_q};
	assign gap_ok_w = last_ok_q && w_q.pts_valid && !d_w[PtsW] && d_w != '0;

	assign in_ch.ready = (st_q == S_IN);
	assign sh_start = (st_q == S_CALC);
	assign id_emit_w = (st_q == S_EMIT) && !split_q && idx_q != cnt_q + HeldW'(self_q);

	amd_share u_share (
		.clk(clk), .arst_n(arst_n), .start(sh_start),
		.num(use_ts_q ? (idx_q < held_q ? dur_rd_q : gap_q) : PtsW'(1)),
		.den(use_ts_q ? total_q : PtsW'(held_q) + PtsW'(1)),
		.m0(w_q.in_dx), .m1(w_q.in_dy), .m2(w_q.in_theta), .m3(w_q.in_scale),
		.done(sh_done), .shares(sh_res)
	);

	always_ff @(posedge clk) begin
		dur_rd_q <= dur_mem[idx_q[IdxW-1:0]];
		if (st_q == S_WAIT && hold_q)
			dur_mem[cnt_q[IdxW-1:0]] <= gap_ok_w ? d_w[PtsW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IN;
			started_q <= 1'b0; anchor_q <= '0; last_q <= '0;
			last_ok_q <= 1'b0; gaps_ok_q <= 1'b1; held_q <= '0;
			idx_q <= '0; cnt_q <= '0;
			out_ch.valid <= 1'b0;
			ovf_q <= 1'b0; split_q <= 1'b0; self_q <= 1'b0;
			hold_q <= 1'b0; flush_q <= 1'b0; use_ts_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready && !id_emit_w) out_ch.valid <= 1'b0;
			case (st_q)
				S_IN: begin
					if (in_ch.valid) begin
						w_q <= in_ch.data;
						st_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					idx_q <= '0;
					ovf_q <= 1'b0; split_q <= 1'b0; self_q <= 1'b0;
					hold_q <= 1'b0; flush_q <= 1'b0;
					cnt_q <= held_q;
					if (w_q.action == ACT_FLUSH) begin
						flush_q <= 1'b1;
						if (held_q == '0) begin
							started_q <= 1'b0; anchor_q <= '0; last_q <= '0;
							last_ok_q <= 1'b0; gaps_ok_q <= 1'b1;
							st_q <= S_IN;
						end else st_q <= S_EMIT;
					end else if (!started_q) begin
						self_q <= 1'b1; held_q <= '0; cnt_q <= '0;
						st_q <= S_EMIT;
					end else if (w_q.is_key || (w_q.is_predicted && !w_q.meas_valid)) begin
						self_q <= 1'b1;
						st_q <= S_EMIT;
					end else if (w_q.is_predicted) begin
						split_q <= 1'b1; self_q <= 1'b1;
						gap_q <= gap_ok_w ? d_w[PtsW-1:0] : '0;
						total_q <= tot_w[PtsW-1:0];
						use_ts_q <= gaps_ok_q && gap_ok_w && !tot_w[PtsW] && tot_w != '0;
						st_q <= S_PUSH;
					end else if (held_q >= HeldW'(MaxHeld)) begin
						ovf_q <= 1'b1;
						st_q <= S_EMIT;
					end else begin
						hold_q <= 1'b1;
						st_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					// hold write happens this cycle's edge path; finish bookkeeping
					if (hold_q) begin
						held_q <= held_q + HeldW'(1);
						gaps_ok_q <= gaps_ok_q && gap_ok_w;
						last_q <= w_q.pts; last_ok_q <= w_q.pts_valid;
						hold_q <= 1'b0;
						st_q <= S_IN;
					end else if (sh_done) begin
						out_ch.valid <= 1'b1;
						out_ch.data <= '{out_dx: sh_res[0 +: MotW],
							out_dy: sh_res[MotW +: MotW],
							out_theta: sh_res[2*MotW +: MotW],
							out_scale: sh_res[3*MotW +: MotW],
							out_confidence: w_q.in_confidence, out_valid: 1'b1,
							out_scene_cut: w_q.in_scene_cut,
							interpolated: held_q != '0, overflowed: 1'b0,
							end_of_run: idx_q == held_q};
						st_q <= S_EMIT;
					end
				end
				S_PUSH: st_q <= S_CALC;
				S_CALC: st_q <= S_WAIT;
				S_EMIT: begin
					if (!out_ch.valid || out_ch.ready) begin
						if (split_q) begin
							if (out_ch.valid && idx_q == held_q) begin
								anchor_q <= w_q.pts; gaps_ok_q <= 1'b1; held_q <= '0;
								last_q <= w_q.pts; last_ok_q <= w_q.pts_valid;
								st_q <= S_IN;
							end else if (out_ch.valid) begin
								idx_q <= idx_q + HeldW'(1);
								st_q <= S_PUSH;
							end
						end else if (idx_q == cnt_q + HeldW'(self_q)) begin
							if (flush_q) begin
								started_q <= 1'b0; anchor_q <= '0; last_q <= '0;
								last_ok_q <= 1'b0; gaps_ok_q <= 1'b1; held_q <= '0;
								st_q <= S_IN;
							end else if (ovf_q) begin
								anchor_q <= last_q; gaps_ok_q <= 1'b1; held_q <= '0;
								cnt_q <= '0; ovf_q <= 1'b0;
								hold_q <= 1'b1;
								st_q <= S_WAIT;
							end else begin
								started_q <= 1'b1;
								anchor_q <= w_q.pts; gaps_ok_q <= 1'b1; held_q <= '0;
								last_q <= w_q.pts; last_ok_q <= w_q.pts_valid;
								st_q <= S_IN;
							end
						end else begin
							out_ch.valid <= 1'b1;
							out_ch.data <= '{out_valid: 1'b1, overflowed: ovf_q,
								end_of_run: idx_q + HeldW'(1) == cnt_q + HeldW'(self_q),
								default: '0};
							idx_q <= idx_q + HeldW'(1);
						end
					end
				end
				default: st_q <= S_IN;
			endcase
		end
	end

	a_ready_only_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid || st_q == S_IN) else $error("ready state");
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HeldW'(MaxHeld)) else $error("hold count overrun");
	a_ovf_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.overflowed |-> out_ch.data.out_dx == '0)
		else $error("overflow result not identity");
endmodule
`default_nettype wire

### bench/anchor_motion_distributor_test.sv
// Testbench for the anchor motion distributor: frame sequences checked against a built-in predictor.
`timescale 1ns / 1ps
module anchor_motion_distributor_test;
	import amd_pkg::*;

	logic clk;
	logic arst_n;
	amd_in_if in_ch ();
	amd_out_if out_ch ();

	anchor_motion_distributor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// predictor state
	bit started;
	logic signed [PtsW-1:0] anchor_pts;
	logic signed [PtsW-1:0] last_pts;
	bit last_pts_ok;
	bit gaps_ok;
	int held_count;
	logic [PtsW-1:0] held_gap [MaxHeld];

	in_word_t frame_q [$];
	out_word_t motion_q [$];
	int mismatches;
	bit hold_off;
	bit hold_sender;

	function automatic out_word_t identity(bit ovf);
		out_word_t w;
		w = '0;
		w.out_valid = 1'b1;
		w.overflowed = ovf;
		return w;
	endfunction

	// round(num * 2^24 / den), ties up
	function automatic longint unsigned frac_q24(longint unsigned num, longint unsigned den);
		longint unsigned q, r;
		q = 0;
		r = num;
		if (den == 0) return 0;
		if (r >= den) begin
			q = 1;
			r -= den;
		end
		for (int i = 0; i < 25; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r -= den;
				q |= 1;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic logic [MotW-1:0] scaled(logic signed [MotW-1:0] m, longint unsigned f);
		longint unsigned mag, r;
		longint v;
		mag = (m < 0) ? longint'(-longint'(m)) : longint'(m);
		r = (mag * f + (64'd1 << 23)) >> 24;
		v = (m < 0) ? -longint'(r) : longint'(r);
		return v[MotW-1:0];
	endfunction

	function automatic void reset_motion_state();
		started = 0;
		anchor_pts = '0;
		last_pts = '0;
		last_pts_ok = 0;
		gaps_ok = 1;
		held_count = 0;
	endfunction

	function automatic void set_anchor(logic signed [PtsW-1:0] p);
		anchor_pts = p;
		gaps_ok = 1;
		held_count = 0;
	endfunction

	function automatic void predict_motion(in_word_t w);
		out_word_t res [$];
		out_word_t o;
		longint d, total;
		bit gap_ok, use_ts;
		longint unsigned gap, dur, f;
		int interval;
		if (w.action == ACT_FLUSH) begin
			for (int i = 0; i < held_count; i++) res.push_back(identity(0));
			reset_motion_state();
		end else begin
			if (!started) begin
				started = 1;
				res.push_back(identity(0));
				set_anchor(w.pts);
			end else begin
				d = longint'(w.pts) - longint'(last_pts);
				gap_ok = last_pts_ok && w.pts_valid && d > 0;
				gap = gap_ok ? longint'(d) : 0;
				if (w.is_key || (w.is_predicted && !w.meas_valid)) begin
					for (int i = 0; i <= held_count; i++) res.push_back(identity(0));
					set_anchor(w.pts);
				end else if (w.is_predicted) begin
					interval = held_count + 1;
					total = longint'(w.pts) - longint'(anchor_pts);
					use_ts = gaps_ok && gap_ok && total > 0;
					for (int i = 0; i < interval; i++) begin
						dur = (i < held_count) ? longint'(held_gap[i]) : gap;
						f = use_ts ? frac_q24(dur, total) : frac_q24(1, interval);
						o = '0;
						o.out_dx = scaled(w.in_dx, f);
						o.out_dy = scaled(w.in_dy, f);
						o.out_theta = scaled(w.in_theta, f);
						o.out_scale = scaled(w.in_scale, f);
						o.out_confidence = w.in_confidence;
						o.out_valid = 1'b1;
						o.out_scene_cut = w.in_scene_cut;
						o.interpolated = interval > 1;
						res.push_back(o);
					end
					set_anchor(w.pts);
				end else begin
					if (held_count >= MaxHeld) begin
						for (int i = 0; i < held_count; i++) res.push_back(identity(1));
						set_anchor(last_pts);
					end
					held_gap[held_count] = gap[PtsW-1:0];
					held_count++;
					gaps_ok = gaps_ok && gap_ok;
				end
			end
			last_pts = w.pts;
			last_pts_ok = w.pts_valid;
		end
		if (res.size() > 0) res[res.size()-1].end_of_run = 1'b1;
		foreach (res[i]) motion_q.push_back(res[i]);
	endfunction

	function automatic int short_or_long_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// input acceptance, seen at the rising edge
	bit in_taken;
	always @(posedge clk) begin
		in_taken = arst_n && in_ch.valid && in_ch.ready;
		if (in_taken) predict_motion(in_ch.data);
	end

	// sender
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			send_gap = 0;
		end else begin
			if (in_taken) send_gap = short_or_long_gap();
			if (!in_ch.valid || in_taken) begin
				if (send_gap > 0 || hold_sender || frame_q.size() == 0) begin
					if (send_gap > 0) send_gap--;
					in_ch.valid <= 1'b0;
				end else begin
					in_ch.valid <= 1'b1;
					in_ch.data <= frame_q.pop_front();
				end
			end
		end
	end

	// receiver
	int recv_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap = 0;
		end else if (hold_off) begin
			out_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			recv_gap = short_or_long_gap();
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (motion_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", out_ch.data);
			end else begin
				exp_w = motion_q.pop_front();
				if (out_ch.data !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", exp_w, out_ch.data);
				end
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		hold_off = 0;
		wait (arst_n);
		repeat (3000) @(posedge clk);
		@(negedge clk);
		hold_off = 1;
		repeat (2000) @(posedge clk);
		@(negedge clk);
		hold_off = 0;
	end

	function automatic in_word_t rand_frame(bit key, bit pred, logic signed [PtsW-1:0] p);
		in_word_t w;
		w.action = ACT_FRAME;
		w.is_key = key;
		w.is_predicted = pred;
		w.meas_valid = $urandom_range(0, 7) != 0;
		w.in_dx = MotW'($urandom);
		w.in_dy = MotW'($urandom);
		w.in_theta = MotW'($urandom);
		w.in_scale = MotW'($urandom);
		w.in_confidence = ConfW'($urandom);
		w.in_scene_cut = 1'($urandom_range(0, 1));
		w.pts = p;
		w.pts_valid = $urandom_range(0, 15) != 0;
		return w;
	endfunction

	task automatic wait_drained();
		while (frame_q.size() > 0 || in_ch.valid || motion_q.size() > 0) @(posedge clk);
	endtask

	logic signed [PtsW-1:0] clock_pts;
	in_word_t w;
	int group_len;
	initial begin
		mismatches = 0;
		hold_sender = 0;
		reset_motion_state();
		// directed: extremes, every frame type, flushes, overflow
		w = rand_frame(1, 0, 48'sh7FFF_FFFF_FFFF);
		frame_q.push_back(w);
		w = rand_frame(0, 0, 48'sh8000_0000_0000);
		frame_q.push_back(w);
		w = rand_frame(0, 1, 48'sh8000_0000_0100);
		w.meas_valid = 1;
		w.in_dx = 24'sh7FFFFF; w.in_dy = 24'sh800000;
		w.in_theta = '1; w.in_scale = '0; w.in_confidence = '1;
		frame_q.push_back(w);
		w = rand_frame(1, 1, 100); frame_q.push_back(w);
		w = rand_frame(0, 1, 200); w.meas_valid = 0; frame_q.push_back(w);
		w = rand_frame(0, 0, 300); frame_q.push_back(w);
		w = rand_frame(0, 0, 300); frame_q.push_back(w); // zero gap
		w = rand_frame(0, 1, 400); w.meas_valid = 1; frame_q.push_back(w);
		w = '0; w.action = ACT_FLUSH; frame_q.push_back(w);
		w = '0; w.action = ACT_FLUSH; frame_q.push_back(w);
		for (int i = 0; i < 18; i++) begin
			w = rand_frame(0, 0, 1000 + i * 10);
			w.pts_valid = 1;
			frame_q.push_back(w);
		end
		w = '1; w.action = ACT_FLUSH; frame_q.push_back(w);
		wait (arst_n);
		wait_drained();
		// sender pause until drained, checked above; now random streams
		clock_pts = 48'($urandom) - 48'sd5000;
		for (int n = 0; n < 420; ) begin
			if ($urandom_range(0, 19) == 0) begin
				w = '0;
				w.action = ACT_FLUSH;
				w.in_dx = MotW'($urandom);
				w.pts = PtsW'({$urandom, $urandom});
				frame_q.push_back(w);
				n++;
			end
			group_len = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 19)
				: $urandom_range(0, 4);
			for (int g = 0; g < group_len; g++) begin
				clock_pts += ($urandom_range(0, 15) == 0) ? -48'sd3 : 48'($urandom_range(1, 3000));
				frame_q.push_back(rand_frame(0, 0, clock_pts));
				n++;
			end
			clock_pts += 48'($urandom_range(1, 3000));
			if ($urandom_range(0, 9) == 0) w = rand_frame(1, 1'($urandom_range(0, 1)), clock_pts);
			else w = rand_frame(0, 1, clock_pts);
			if ($urandom_range(0, 29) == 0) w.pts = PtsW'({$urandom, $urandom});
			frame_q.push_back(w);
			n++;
			if (n > 150 && n < 170 && !hold_sender) begin
				wait_drained();
				hold_sender = 1;
				repeat (50) @(posedge clk);
				hold_sender = 0;
			end
			while (frame_q.size() > 40) @(posedge clk);
		end
		w = '0; w.action = ACT_FLUSH; frame_q.push_back(w);
		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && motion_q.size() == 0) begin
			$display("[anchor_motion_distributor] OK");
		end else begin
			$display("[anchor_motion_distributor] ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[anchor_motion_distributor] ERROR");
		$finish;
	end
endmodule

### anchor_motion_distributor.f
design/amd_pkg.sv
design/amd_if.sv
design/amd_share.sv
design/anchor_motion_distributor.sv
bench/anchor_motion_distributor_test.sv
